// File: rtl/core/ffba_pkg.sv
// shared types and constants for the first-fit block allocator
// no dependencies
`default_nettype none

package ffba_pkg;

    localparam int MAX_BLOCKS = 64;
    localparam int IDX_W      = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);

    localparam logic [31:0] HEAP_LIMIT_RST  = 32'd1048576;
    localparam logic [7:0]  HEADER_BYTES_RST = 8'd24;

    typedef enum logic [1:0] {
        KIND_ALLOC   = 2'd0,
        KIND_RELEASE = 2'd1,
        KIND_REALLOC = 2'd2,
        KIND_NONE    = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK   = 3'd0,
        ST_OOM  = 3'd1,
        ST_ZERO = 3'd2,
        ST_BAD  = 3'd3,
        ST_NULL = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        CFG_HEAP_BASE    = 2'd0,
        CFG_HEAP_LIMIT   = 2'd1,
        CFG_HEADER_BYTES = 2'd2,
        CFG_UNUSED       = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        MODE_FIT  = 1'b0,
        MODE_FIND = 1'b1
    } t_mode;

    typedef enum logic [1:0] {
        WR_NONE = 2'd0,
        WR_TAKE = 2'd1,
        WR_FREE = 2'd2,
        WR_NEW  = 2'd3
    } t_wr_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_SCAN_FIND,
        S_LAUNCH_FIT,
        S_SCAN_FIT,
        S_APPEND,
        S_FREE_OLD,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] size;
        logic [31:0] handle;
    } t_in_word;

    typedef struct packed {
        logic [31:0] address;
        logic [31:0] old_address;
        logic [31:0] copy_bytes;
        logic [2:0]  status;
    } t_out_word;

    typedef struct packed {
        t_mode       mode;
        logic [31:0] key;
    } t_query;

    // search token travelling down the chain with the first hit it met
    typedef struct packed {
        logic             tok;
        logic             found;
        logic             free;
        logic [IDX_W-1:0] idx;
        logic [31:0]      start;
        logic [31:0]      size;
    } t_probe;

    typedef struct packed {
        t_wr_op           op;
        logic [IDX_W-1:0] idx;
        logic [31:0]      start;
        logic [31:0]      size;
    } t_cell_wr;

endpackage

`default_nettype wire

// File: rtl/core/ffba_cell.sv
// one table entry of the allocator chain: holds start, size, free mark
// and passes the search token to its neighbor; uses ffba_pkg
`default_nettype none

module ffba_cell import ffba_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [IDX_W-1:0] i_idx,
    input  wire t_query           i_query,
    input  wire t_cell_wr         i_wr,
    input  wire t_probe           i_probe,
    output t_probe                o_probe
);

    logic        r_valid;
    logic        r_free;
    logic [31:0] r_start;
    logic [31:0] r_size;
    t_probe      r_probe;
    t_probe      n_probe;
    logic        w_match;
    logic        w_sel;

    assign w_sel = (i_wr.op != WR_NONE) && (i_wr.idx == i_idx);

    always_comb begin
        if (i_query.mode == MODE_FIT) begin
            w_match = r_valid && r_free && (r_size >= i_query.key);
        end else begin
            w_match = r_valid && (r_start == i_query.key);
        end
    end

    // first hit wins, later cells only forward
    always_comb begin
        n_probe = i_probe;
        if (i_probe.tok && !i_probe.found && w_match) begin
            n_probe.found = 1'b1;
            n_probe.free  = r_free;
            n_probe.idx   = i_idx;
            n_probe.start = r_start;
            n_probe.size  = r_size;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probe <= '0;
            r_valid <= 1'b0;
        end else begin
            r_probe <= n_probe;
            if (w_sel && i_wr.op == WR_NEW) begin
                r_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_sel) begin
            case (i_wr.op)
                WR_TAKE: r_free <= 1'b0;
                WR_FREE: r_free <= 1'b1;
                WR_NEW: begin
                    r_free  <= 1'b0;
                    r_start <= i_wr.start;
                    r_size  <= i_wr.size;
                end
                default: ;
            endcase
        end
    end

    assign o_probe = r_probe;

endmodule

`default_nettype wire

// File: rtl/core/ffba_ctrl.sv
// sequencer of the allocator: config registers, heap break, entry count,
// launches searches down the cell chain and writes back; uses ffba_pkg
`default_nettype none

module ffba_ctrl import ffba_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire t_in_word    i_in,
    output logic             o_valid,
    input  wire logic        i_stall,
    output t_out_word        o_out,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data,
    output t_query           o_query,
    output t_probe           o_launch,
    input  wire t_probe      i_result,
    output t_cell_wr         o_wr
);

    t_state           r_state, n_state;
    logic [31:0]      r_base, r_limit;
    logic [7:0]       r_hdr;
    logic [CNT_W-1:0] r_count, n_count;
    logic [31:0]      r_used, n_used;
    t_in_word         r_req, n_req;
    t_query           r_query, n_query;
    logic             r_move, n_move;
    logic [IDX_W-1:0] r_old_idx, n_old_idx;
    logic [31:0]      r_old_size, n_old_size;
    t_out_word        r_res, n_res;
    logic             r_ovld, n_ovld;
    t_out_word        r_oword, n_oword;
    logic             w_accept;
    logic             w_full;
    logic [33:0]      w_need;
    logic             w_oom;
    logic [31:0]      w_new_addr;

    assign w_accept   = i_valid && (r_state == S_IDLE);
    assign w_full     = (r_count >= CNT_W'(MAX_BLOCKS));
    assign w_need     = {2'b00, r_used} + {26'd0, r_hdr} + {2'b00, r_req.size};
    assign w_oom      = w_full || (w_need > {2'b00, r_limit});
    assign w_new_addr = r_base + r_used + {24'd0, r_hdr};

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_valid) n_state = S_START;
            S_START: begin
                case (t_kind'(r_req.kind))
                    KIND_ALLOC:   n_state = (r_req.size == '0) ? S_DONE : S_SCAN_FIT;
                    KIND_RELEASE: n_state = (r_req.handle == '0) ? S_DONE : S_SCAN_FIND;
                    KIND_REALLOC: begin
                        if (r_req.handle != '0) begin
                            n_state = S_SCAN_FIND;
                        end else begin
                            n_state = (r_req.size == '0) ? S_DONE : S_SCAN_FIT;
                        end
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_SCAN_FIND: begin
                if (i_result.tok) begin
                    if (!i_result.found || i_result.free ||
                        r_req.kind == KIND_RELEASE ||
                        i_result.size >= r_req.size) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_LAUNCH_FIT;
                    end
                end
            end
            S_LAUNCH_FIT: n_state = S_SCAN_FIT;
            S_SCAN_FIT: begin
                if (i_result.tok) begin
                    if (!i_result.found) n_state = S_APPEND;
                    else n_state = r_move ? S_FREE_OLD : S_DONE;
                end
            end
            S_APPEND:   n_state = (!w_oom && r_move) ? S_FREE_OLD : S_DONE;
            S_FREE_OLD: n_state = S_DONE;
            S_DONE:     if (!r_ovld || !i_stall) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_req      = r_req;
        n_query    = r_query;
        n_move     = r_move;
        n_old_idx  = r_old_idx;
        n_old_size = r_old_size;
        n_res      = r_res;
        n_count    = r_count;
        n_used     = r_used;
        n_ovld     = r_ovld && i_stall;
        n_oword    = r_oword;
        o_launch   = '0;
        o_wr       = '0;
        o_wr.op    = WR_NONE;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_req  = i_in;
                    n_move = 1'b0;
                    n_res  = '0;
                    n_res.status = ST_NULL;
                    if ((i_in.kind == KIND_RELEASE || i_in.kind == KIND_REALLOC) &&
                        i_in.handle != '0) begin
                        n_query.mode = MODE_FIND;
                        n_query.key  = i_in.handle;
                    end else begin
                        n_query.mode = MODE_FIT;
                        n_query.key  = i_in.size;
                    end
                end
            end
            S_START: begin
                if (r_req.kind == KIND_ALLOC || r_req.kind == KIND_REALLOC) begin
                    if (r_req.kind == KIND_ALLOC || r_req.handle == '0) begin
                        if (r_req.size == '0) n_res.status = ST_ZERO;
                        else o_launch.tok = 1'b1;
                    end else begin
                        o_launch.tok = 1'b1;
                    end
                end else if (r_req.kind == KIND_RELEASE && r_req.handle != '0) begin
                    o_launch.tok = 1'b1;
                end
            end
            S_SCAN_FIND: begin
                if (i_result.tok) begin
                    if (!i_result.found || i_result.free) begin
                        n_res.status = ST_BAD;
                    end else if (r_req.kind == KIND_RELEASE) begin
                        o_wr.op      = WR_FREE;
                        o_wr.idx     = i_result.idx;
                        n_res.status = ST_OK;
                    end else if (i_result.size >= r_req.size) begin
                        n_res.address = r_req.handle;
                        n_res.status  = ST_OK;
                    end else begin
                        n_move       = 1'b1;
                        n_old_idx    = i_result.idx;
                        n_old_size   = i_result.size;
                        n_query.mode = MODE_FIT;
                        n_query.key  = r_req.size;
                    end
                end
            end
            S_LAUNCH_FIT: o_launch.tok = 1'b1;
            S_SCAN_FIT: begin
                if (i_result.tok && i_result.found) begin
                    o_wr.op       = WR_TAKE;
                    o_wr.idx      = i_result.idx;
                    n_res.address = i_result.start;
                    n_res.status  = ST_OK;
                end
            end
            S_APPEND: begin
                if (w_oom) begin
                    n_res.address = '0;
                    n_res.status  = ST_OOM;
                end else begin
                    o_wr.op       = WR_NEW;
                    o_wr.idx      = r_count[IDX_W-1:0];
                    o_wr.start    = w_new_addr;
                    o_wr.size     = r_req.size;
                    n_count       = r_count + 1'b1;
                    n_used        = w_need[31:0];
                    n_res.address = w_new_addr;
                    n_res.status  = ST_OK;
                end
            end
            S_FREE_OLD: begin
                o_wr.op           = WR_FREE;
                o_wr.idx          = r_old_idx;
                n_res.old_address = r_req.handle;
                n_res.copy_bytes  = r_old_size;
            end
            S_DONE: begin
                if (!r_ovld || !i_stall) begin
                    n_ovld  = 1'b1;
                    n_oword = r_res;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_base  <= '0;
            r_limit <= HEAP_LIMIT_RST;
            r_hdr   <= HEADER_BYTES_RST;
            r_count <= '0;
            r_used  <= '0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_used  <= n_used;
            r_ovld  <= n_ovld;
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_HEAP_BASE:    r_base  <= i_cfg_data;
                    CFG_HEAP_LIMIT:   r_limit <= i_cfg_data;
                    CFG_HEADER_BYTES: r_hdr   <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_query    <= n_query;
        r_move     <= n_move;
        r_old_idx  <= n_old_idx;
        r_old_size <= n_old_size;
        r_res      <= n_res;
        r_oword    <= n_oword;
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_ovld;
    assign o_out   = r_oword;
    assign o_query = r_query;

endmodule

`default_nettype wire

// File: rtl/core/first_fit_block_allocator.sv
// top level of the first-fit block allocator: sequencer plus a chain of
// MAX_BLOCKS entry cells; uses ffba_pkg, ffba_ctrl, ffba_cell
//
// channel  direction  handshake          payload
// in       input      i_valid / o_stall  i_in  (t_in_word)
// out      output     o_valid / i_stall  o_out (t_out_word)
// cfg      input      i_cfg_we           i_cfg_idx, i_cfg_data
//
// one word at a time; a search walks the cell chain one cell per cycle.
// a release runs a find search; an allocate runs a fit search and appends a
// new entry when no free entry fits; a reallocate that must move runs a find
// search, a fit search, an append if needed, then frees the old entry; zero-size,
// null and unused-kind words skip the chain; no clearing pass at reset.
// while i_stall holds the output register, the next result waits and o_stall stays high
`default_nettype none

module first_fit_block_allocator import ffba_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire t_in_word    i_in,
    output logic             o_valid,
    input  wire logic        i_stall,
    output t_out_word        o_out,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data
);

    t_query   w_query;
    t_cell_wr w_wr;
    t_probe   w_link [MAX_BLOCKS+1];

    ffba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_in       (i_in),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_out      (o_out),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_query    (w_query),
        .o_launch   (w_link[0]),
        .i_result   (w_link[MAX_BLOCKS]),
        .o_wr       (w_wr)
    );

    for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
        ffba_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (IDX_W'(g)),
            .i_query (w_query),
            .i_wr    (w_wr),
            .i_probe (w_link[g]),
            .o_probe (w_link[g+1])
        );
    end

endmodule

`default_nettype wire

// File: bench/tb.sv
// self-checking bench for first_fit_block_allocator: random and directed words,
// own table model predicts each result; depends on ffba_pkg and the rtl top
`default_nettype none

module tb;
    import ffba_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        out_stall = 1'b0;
    logic        out_valid;
    t_in_word    in_word = '0;
    t_out_word   out_word;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_idx = CFG_HEAP_BASE;
    logic [31:0] cfg_data = '0;
    logic        blk_stall;

    first_fit_block_allocator u_top (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_stall(blk_stall), .i_in(in_word),
        .o_valid(out_valid), .i_stall(out_stall), .o_out(out_word),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    initial begin
        forever #6 clk = ~clk;
    end

    // allocator table model
    logic [31:0] tbl_start [MAX_BLOCKS];
    logic [31:0] tbl_size  [MAX_BLOCKS];
    logic        tbl_free  [MAX_BLOCKS];
    int          tbl_count;
    logic [31:0] used_bytes;
    logic [31:0] m_base, m_limit;
    logic [7:0]  m_hdr;

    t_in_word  pending_words [$];
    t_out_word expected_words [$];
    logic [31:0] live_handles [$];
    int  errors = 0;
    int  quiet_cycles = 0;
    bit  calm = 1'b0;
    bit  feeding = 1'b0;

    function automatic logic [31:0] grant_block(input logic [31:0] sz,
                                                output t_status st);
        logic [63:0] need;
        logic [31:0] addr;
        if (sz == 0) begin
            st = ST_ZERO;
            return '0;
        end
        for (int i = 0; i < tbl_count; i++) begin
            if (tbl_free[i] && tbl_size[i] >= sz) begin
                tbl_free[i] = 1'b0;
                st = ST_OK;
                return tbl_start[i];
            end
        end
        need = 64'(used_bytes) + 64'(m_hdr) + 64'(sz);
        if (tbl_count >= MAX_BLOCKS || need > 64'(m_limit)) begin
            st = ST_OOM;
            return '0;
        end
        addr = m_base + used_bytes + 32'(m_hdr);
        tbl_start[tbl_count] = addr;
        tbl_size[tbl_count]  = sz;
        tbl_free[tbl_count]  = 1'b0;
        tbl_count++;
        used_bytes = need[31:0];
        st = ST_OK;
        return addr;
    endfunction

    function automatic int lookup_handle(input logic [31:0] h);
        for (int i = 0; i < tbl_count; i++)
            if (tbl_start[i] == h) return i;
        return -1;
    endfunction

    function automatic t_out_word predict_word(input t_in_word w);
        t_out_word r;
        t_status   st;
        int        e;
        logic [31:0] old_sz;
        r = '0;
        st = ST_NULL;
        if (w.kind == KIND_ALLOC) begin
            r.address = grant_block(w.size, st);
        end else if (w.kind == KIND_RELEASE) begin
            if (w.handle != 0) begin
                e = lookup_handle(w.handle);
                if (e < 0 || tbl_free[e]) st = ST_BAD;
                else begin
                    tbl_free[e] = 1'b1;
                    st = ST_OK;
                end
            end
        end else if (w.kind == KIND_REALLOC) begin
            if (w.handle == 0) begin
                r.address = grant_block(w.size, st);
            end else begin
                e = lookup_handle(w.handle);
                if (e < 0 || tbl_free[e]) st = ST_BAD;
                else if (tbl_size[e] >= w.size) begin
                    r.address = w.handle;
                    st = ST_OK;
                end else begin
                    old_sz = tbl_size[e];
                    r.address = grant_block(w.size, st);
                    if (st == ST_OK) begin
                        tbl_free[e] = 1'b1;
                        r.old_address = w.handle;
                        r.copy_bytes = old_sz;
                    end else r.address = '0;
                end
            end
        end
        r.status = st;
        return r;
    endfunction

    // driver
    always @(posedge clk) begin
        if (in_valid && !blk_stall) begin
            expected_words.push_back(predict_word(in_word));
        end
        if (!in_valid || !blk_stall) begin
            if (feeding && pending_words.size() > 0 &&
                (calm || $urandom_range(99) >= 8)) begin
                in_word  <= pending_words.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk) begin
        t_out_word exp_w;
        if (out_valid && !out_stall) begin
            if (expected_words.size() == 0) begin
                $error("result word with nothing expected");
                errors++;
            end else begin
                exp_w = expected_words.pop_front();
                if (out_word.address != exp_w.address) begin
                    $error("address exp %h got %h", exp_w.address, out_word.address);
                    errors++;
                end
                if (out_word.old_address != exp_w.old_address) begin
                    $error("old_address exp %h got %h", exp_w.old_address,
                           out_word.old_address);
                    errors++;
                end
                if (out_word.copy_bytes != exp_w.copy_bytes) begin
                    $error("copy_bytes exp %h got %h", exp_w.copy_bytes,
                           out_word.copy_bytes);
                    errors++;
                end
                if (out_word.status != exp_w.status) begin
                    $error("status exp %0d got %0d", exp_w.status, out_word.status);
                    errors++;
                end
                if (exp_w.status == ST_OK && exp_w.address != 0)
                    live_handles.push_back(exp_w.address);
            end
        end
        out_stall <= calm ? 1'b0 : ($urandom_range(99) < 8);
    end

    // watchdog
    always @(posedge clk) begin
        if ((in_valid && !blk_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] val);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_HEAP_BASE:    m_base  = val;
            CFG_HEAP_LIMIT:   m_limit = val;
            CFG_HEADER_BYTES: m_hdr   = val[7:0];
            default: ;
        endcase
    endtask

    task automatic push_word(input t_kind k, input logic [31:0] sz,
                             input logic [31:0] h);
        t_in_word w;
        w.kind = k;
        w.size = sz;
        w.handle = h;
        pending_words.push_back(w);
    endtask

    // sample at the falling edge so driver updates have settled
    task automatic drain_all();
        feeding = 1'b1;
        do @(negedge clk);
        while (pending_words.size() != 0 || in_valid || expected_words.size() != 0);
        repeat (2 * MAX_BLOCKS + 20) @(posedge clk);
        feeding = 1'b0;
    endtask

    function automatic logic [31:0] pick_handle();
        int r;
        r = $urandom_range(99);
        if (live_handles.size() > 0 && r < 75)
            return live_handles[$urandom_range(live_handles.size() - 1)];
        if (r < 85) return '0;
        return $urandom();
    endfunction

    function automatic logic [31:0] pick_size();
        int r;
        r = $urandom_range(99);
        if (r < 5) return '0;
        if (r < 80) return $urandom_range(1, 300);
        if (r < 95) return $urandom_range(1, 40000);
        return $urandom();
    endfunction

    task automatic random_phase(input int n);
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (r < 40) push_word(KIND_ALLOC, pick_size(), $urandom());
            else if (r < 70) push_word(KIND_RELEASE, $urandom(), pick_handle());
            else if (r < 97) push_word(KIND_REALLOC, pick_size(), pick_handle());
            else push_word(KIND_NONE, $urandom(), $urandom());
        end
        drain_all();
    endtask

    initial begin
        m_base = '0;
        m_limit = HEAP_LIMIT_RST;
        m_hdr = HEADER_BYTES_RST;
        tbl_count = 0;
        used_bytes = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset settings
        push_word(KIND_ALLOC, 32'd0, 32'd0);
        push_word(KIND_ALLOC, 32'd100, 32'hFFFF_FFFF);
        push_word(KIND_ALLOC, 32'd50, 32'd0);
        push_word(KIND_RELEASE, 32'd0, 32'd0);
        push_word(KIND_RELEASE, 32'hFFFF_FFFF, 32'd24);
        push_word(KIND_RELEASE, 32'd0, 32'd24);
        push_word(KIND_RELEASE, 32'd0, 32'h1234_5677);
        push_word(KIND_ALLOC, 32'd80, 32'd0);
        push_word(KIND_REALLOC, 32'd0, 32'd148);
        push_word(KIND_REALLOC, 32'd40, 32'd148);
        push_word(KIND_REALLOC, 32'd500, 32'd148);
        push_word(KIND_REALLOC, 32'd10, 32'd0);
        push_word(KIND_REALLOC, 32'd10, 32'd148);
        push_word(KIND_REALLOC, 32'hFFFF_FFFF, 32'd24);
        push_word(KIND_ALLOC, 32'hFFFF_FFFF, 32'd0);
        push_word(KIND_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        drain_all();

        // near top of address space, wrap, big header
        write_reg(CFG_HEAP_BASE, 32'hFFFF_FF00);
        write_reg(CFG_HEADER_BYTES, 32'h0000_00FF);
        write_reg(CFG_HEAP_LIMIT, 32'hFFFF_FFFF);
        push_word(KIND_ALLOC, 32'd1, 32'd0);
        push_word(KIND_ALLOC, 32'hFFFF_F000, 32'd0);
        push_word(KIND_ALLOC, 32'd1000, 32'd0);
        drain_all();
        random_phase(120);

        write_reg(CFG_HEAP_LIMIT, 32'd0);
        write_reg(CFG_HEADER_BYTES, 32'd0);
        random_phase(60);

        write_reg(CFG_HEAP_LIMIT, 32'd20000);
        write_reg(CFG_HEAP_BASE, $urandom());
        write_reg(CFG_HEADER_BYTES, $urandom_range(255));
        random_phase(150);

        calm = 1'b1;
        write_reg(CFG_HEAP_LIMIT, $urandom());
        write_reg(CFG_HEADER_BYTES, 32'd16);
        random_phase(80);
        calm = 1'b0;

        write_reg(CFG_HEAP_BASE, 32'd0);
        write_reg(CFG_HEAP_LIMIT, 32'hFFFF_FFFF);
        random_phase(140);

        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

`default_nettype wire

// File: sim.f
rtl/core/ffba_pkg.sv
rtl/core/ffba_cell.sv
rtl/core/ffba_ctrl.sv
rtl/core/first_fit_block_allocator.sv
bench/tb.sv
